// File: src/twrtc_pkg.sv
package twrtc_pkg;

  // pin sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_DRIVE,
    PH_CE_LOW,
    PH_CLK_LOW,
    PH_CE_HIGH,
    PH_SETUP,
    PH_CLK_HIGH,
    PH_CLK_FALL,
    PH_RELEASE,
    PH_END_CE,
    PH_END_REL
  } phase_e;

  // action codes carried with each tick
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd2;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  // sequencer state, pins included
  typedef struct packed {
    phase_e     phase;
    logic [7:0] timer;
    logic [3:0] bit_count;
    logic [7:0] shift_out;
    logic [7:0] pending;
    logic [7:0] shift_in;
    logic       is_read;
    logic       ce;
    logic       clk;
    logic       io;
    logic       drive;
    logic [7:0] read_reg;
  } state_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] read_data;
    logic       done;
    logic       busy;
    logic       io_drive;
    logic       io_out;
    logic       serial_clock;
    logic       chip_enable;
  } res_t;

  // enter a phase: apply its pin action and restart the timer
  function automatic state_t enter_phase(state_t s, phase_e ph, logic [7:0] len);
    state_t r;
    r       = s;
    r.phase = ph;
    r.timer = len;
    case (ph)
      PH_DRIVE:    r.drive = 1'b1;
      PH_CE_LOW:   r.ce    = 1'b0;
      PH_CLK_LOW:  r.clk   = 1'b0;
      PH_CE_HIGH:  r.ce    = 1'b1;
      PH_SETUP: begin
        if (r.is_read && r.bit_count[3]) begin
          r.shift_in = r.shift_in >> 1;
        end else begin
          r.io        = r.shift_out[0];
          r.shift_out = r.shift_out >> 1;
        end
      end
      PH_CLK_HIGH: r.clk   = 1'b1;
      PH_CLK_FALL: r.clk   = 1'b0;
      PH_RELEASE:  r.drive = 1'b0;
      PH_END_CE:   r.ce    = 1'b0;
      PH_END_REL:  r.drive = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

endpackage

// File: src/twrtc_seq.sv
module twrtc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic [1:0]         action_i,
  input  logic [7:0]         address_i,
  input  logic [7:0]         write_data_i,
  input  logic               io_in_i,
  input  logic [7:0]         phase_ticks_i,
  output twrtc_pkg::res_t    res_o
);

  twrtc_pkg::state_t st_q, st_d;
  logic [7:0]        len;
  logic              done;

  // zero phase length behaves as one
  assign len = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;

  // next state for this tick
  always_comb begin
    st_d = st_q;
    done = 1'b0;
    if (st_q.phase == twrtc_pkg::PH_IDLE) begin
      if (action_i == twrtc_pkg::ACT_WRITE || action_i == twrtc_pkg::ACT_READ) begin
        st_d.is_read   = (action_i == twrtc_pkg::ACT_READ);
        st_d.shift_out = st_d.is_read ? address_i + 8'd1 : address_i;
        st_d.pending   = write_data_i;
        st_d.shift_in  = 8'd0;
        st_d.bit_count = 4'd0;
        st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_DRIVE, len);
      end
    end else begin
      st_d.timer = st_q.timer - 8'd1;
      if (st_d.timer == 8'd0) begin
        case (st_q.phase)
          twrtc_pkg::PH_DRIVE:
            st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_CE_LOW, len);
          twrtc_pkg::PH_CE_LOW:
            st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_CLK_LOW, len);
          twrtc_pkg::PH_CLK_LOW:
            st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_CE_HIGH, len);
          twrtc_pkg::PH_CE_HIGH:
            st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_SETUP, len);
          twrtc_pkg::PH_SETUP:
            st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_CLK_HIGH, len);
          twrtc_pkg::PH_CLK_HIGH:
            st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_CLK_FALL, len);
          twrtc_pkg::PH_CLK_FALL: begin
            st_d.bit_count = st_q.bit_count + 4'd1;
            if (st_d.bit_count == 4'd0) begin
              st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_END_CE, len);
            end else if (st_d.bit_count == 4'd8 && st_q.is_read) begin
              st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_RELEASE, len);
            end else begin
              if (st_d.bit_count == 4'd8) begin
                st_d.shift_out = st_q.pending;
              end
              st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_SETUP, len);
            end
          end
          twrtc_pkg::PH_RELEASE:
            st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_SETUP, len);
          twrtc_pkg::PH_END_CE: begin
            if (st_q.is_read) begin
              st_d.read_reg = st_q.shift_in;
              st_d.phase    = twrtc_pkg::PH_IDLE;
              st_d.timer    = 8'd0;
              done          = 1'b1;
            end else begin
              st_d = twrtc_pkg::enter_phase(st_d, twrtc_pkg::PH_END_REL, len);
            end
          end
          default: begin
            st_d.phase = twrtc_pkg::PH_IDLE;
            st_d.timer = 8'd0;
            done       = 1'b1;
          end
        endcase
        // sample the data pin ahead of each read clock
        if (!done && st_d.phase == twrtc_pkg::PH_SETUP && st_d.is_read &&
            st_d.bit_count[3] && io_in_i) begin
          st_d.shift_in = st_d.shift_in | 8'h80;
        end
      end
    end
  end

  // result of this tick
  always_comb begin
    res_o.chip_enable  = st_d.ce;
    res_o.serial_clock = st_d.clk;
    res_o.io_out       = st_d.io;
    res_o.io_drive     = st_d.drive;
    res_o.busy         = (st_d.phase != twrtc_pkg::PH_IDLE);
    res_o.done         = done;
    res_o.read_data    = st_d.read_reg;
  end

  // state register, moves once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance_i) begin
      st_q <= st_d;
    end
  end

endmodule

// File: src/twrtc_skid.sv
module twrtc_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  twrtc_pkg::res_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output twrtc_pkg::res_t  out_data_o
);

  logic            out_v_q, skid_v_q;
  twrtc_pkg::res_t out_q, skid_q;
  logic            push;

  assign in_ready_o  = !skid_v_q;
  assign push        = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (push) begin
      if (out_v_q && !out_ready_i) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_ready_i || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      if (out_v_q && !out_ready_i) begin
        skid_q <= in_data_i;
      end else begin
        out_q <= in_data_i;
      end
    end else if ((out_ready_i || !out_v_q) && skid_v_q) begin
      out_q <= skid_q;
    end
  end

endmodule

// File: src/three_wire_rtc_serial_master.sv
// Three-wire serial master (chip enable, serial clock, bidirectional data pin).
// Each transaction on the s_axis channel is one time tick: an action (tick only,
// start write, start read), address, write byte and the sampled data pin level.
// Each tick yields exactly one m_axis transaction with the pin levels after the
// tick, busy, a done strobe and the byte of the last completed read.
// A write sends the address then the data byte, LSB first; a read sends
// address + 1 and samples eight bits LSB first. Each pin phase lasts
// phase_ticks ticks, set through the cfg channel; the user must write it only
// while no transfer runs, which the block does not enforce. A tick's result is
// registered in the output stage. One tick per cycle is accepted while the
// output is not stalled. When the receiver stalls, one further tick is taken
// into a skid stage and s_axis_tready then drops until the output drains.
// Reset clears the sequencer to idle with all pins low and the data pin
// released, empties the output stage and sets phase_ticks to 2.
module three_wire_rtc_serial_master (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // action[1:0], address[9:2], write_data[17:10], io_in[18], zero[23:19]
  input  logic [twrtc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // chip_enable[0], serial_clock[1], io_out[2], io_drive[3], busy_res[4],
  // done_res[5], read_data[13:6], zero[15:14]
  output logic [twrtc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [7:0]                          cfg_data_i
);

  logic [7:0]      phase_ticks_q;
  logic            accept;
  twrtc_pkg::res_t seq_res, out_res;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // phase length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= twrtc_pkg::PHASE_TICKS_RST;
    end else if (cfg_valid_i) begin
      phase_ticks_q <= cfg_data_i;
    end
  end

  // pin sequencer
  twrtc_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (accept),
    .action_i      (s_axis_tdata[1:0]),
    .address_i     (s_axis_tdata[9:2]),
    .write_data_i  (s_axis_tdata[17:10]),
    .io_in_i       (s_axis_tdata[18]),
    .phase_ticks_i (phase_ticks_q),
    .res_o         (seq_res)
  );

  // result register with skid stage
  twrtc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (seq_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {2'b00, out_res};

`ifndef ASSERT_OFF
  // input only stalls while a result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // output is valid in the next cycle after every accepted tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  // completion strobe never comes with busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[5]) |-> !m_axis_tdata[4])
    else $error("done and busy together");
`endif

endmodule
